FILE: rtl/core/icmp_pkg.sv
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Shared sizes, verdict codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package icmp_pkg;

  localparam int MAX_WORDS = 64;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);

  localparam logic [2:0] V_REPLY      = 3'd0;
  localparam logic [2:0] V_CSUM_ERR   = 3'd1;
  localparam logic [2:0] V_ECHO_REPLY = 3'd2;
  localparam logic [2:0] V_TIME_EXC   = 3'd3;
  localparam logic [2:0] V_OTHER      = 3'd4;
  localparam logic [2:0] V_TOO_LONG   = 3'd5;

  localparam logic [7:0] T_ECHO_REQ = 8'd8;
  localparam logic [7:0] T_ECHO_REP = 8'd0;
  localparam logic [7:0] T_TIME_EXC = 8'd11;

  typedef struct packed {
    logic load;
    logic fold;
    logic status;
    logic lat;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic reply;
    logic last;
  } sts_t;

endpackage

FILE: rtl/core/icmp_echo_responder_top.sv
// Sequence: after the edge that takes the final word, the controller passes
//   S_FOLD and S_DECIDE; a status item is then offered in S_SEND, while each
//   reply word is formed in S_LAT and handed over in S_SEND.
// Throughput: one word per cycle while loading; a packet is taken only after
//   every result of the previous one is delivered.
// Reset: synchronous active-low rst_n clears control state; reply_ttl resets to 255.
// ----------------------------------------------------------------------------
// ICMP echo responder top level
// Buffers an IPv4 packet, answers echo requests and reports other outcomes.
// ----------------------------------------------------------------------------
module icmp_echo_responder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_word,
  input  logic [5:0]  in_header_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word,
  output logic [3:0]  out_bytes,
  output logic        out_last,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_peer_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_reply_ttl
);

  logic [7:0]     ttl_r;
  icmp_pkg::cmd_t cmd;
  icmp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= 8'd255;
    end else if (cfg_valid) begin
      ttl_r <= cfg_reply_ttl;
    end
  end

  icmp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_word (in_last_word),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  icmp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .in_header_len  (in_header_len),
    .ttl            (ttl_r),
    .out_word       (out_word),
    .out_bytes      (out_bytes),
    .out_last       (out_last),
    .out_verdict    (out_verdict),
    .out_peer_addr  (out_peer_addr)
  );

endmodule

FILE: rtl/core/icmp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module icmp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/icmp_ctrl.sv
// ----------------------------------------------------------------------------
// ICMP responder controller
// Sequences load, checksum fold, decision and word replay.
// ----------------------------------------------------------------------------
module icmp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_word,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  icmp_pkg::sts_t sts,
  output icmp_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_FOLD,
    S_DECIDE,
    S_LAT,
    S_SEND
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load   = (state_r == S_LOAD) && in_valid;
    cmd.fold   = (state_r == S_FOLD);
    cmd.status = (state_r == S_DECIDE) && !sts.reply;
    cmd.lat    = (state_r == S_LAT);
    cmd.clear  = (state_r == S_SEND) && out_ready && sts.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_valid && in_last_word) state_r <= S_FOLD;
        end
        S_FOLD: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.reply) begin
            state_r <= S_LAT;
          end else begin
            state_r     <= S_SEND;
            out_valid_r <= 1'b1;
          end
        end
        S_LAT: begin
          state_r     <= S_SEND;
          out_valid_r <= 1'b1;
        end
        S_SEND: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= sts.last ? S_LOAD : S_LAT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: rtl/core/icmp_dp.sv
// ----------------------------------------------------------------------------
// ICMP responder datapath
// Packet store, running checksums, header captures and reply rewrite.
// ----------------------------------------------------------------------------
module icmp_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  icmp_pkg::cmd_t           cmd,
  output icmp_pkg::sts_t           sts,
  input  logic [63:0]              in_data_word,
  input  logic [3:0]               in_valid_bytes,
  input  logic                     in_last_word,
  input  logic [5:0]               in_header_len,
  input  logic [7:0]               ttl,
  output logic [63:0]              out_word,
  output logic [3:0]               out_bytes,
  output logic                     out_last,
  output logic [2:0]               out_verdict,
  output logic [31:0]              out_peer_addr
);

  localparam int CW = icmp_pkg::CNT_W;
  localparam int IW = CW + 3;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int j = 0; j < 8; j++) begin
      m[63-8*j -: 8] = (4'(j) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [15:0] csum16(input logic [31:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return ~f2[15:0];
  endfunction

  logic [CW-1:0] wc_r, ptr_r;
  logic          ovf_r;
  logic [5:0]    hl_r;
  logic [15:0]   tl_r;
  logic [3:0]    vb_r;
  logic [31:0]   s1_r, s2_r, s3_r;
  logic [7:0]    typ_r;
  logic [31:0]   a12_r, a16_r;
  logic [2:0]    verdict_r;
  logic [15:0]   ic_r, hc_r;
  logic [63:0]   out_word_r;
  logic [3:0]    out_bytes_r;
  logic          out_last_r;
  logic [2:0]    out_verdict_r;
  logic [31:0]   out_peer_r;

  logic [3:0]    vb_n, nb;
  logic [63:0]   dm, q, xf;
  logic          first, last_w;
  logic [5:0]    hl_c;
  logic [15:0]   tl_c;
  logic [31:0]   s1_nxt, s2_nxt, s3_nxt;
  logic [7:0]    typ_nxt;
  logic [2:0]    verdict_nxt;
  logic [3:0]    lat_bytes;

  assign vb_n  = (in_valid_bytes == 4'd0 || in_valid_bytes > 4'd8) ? 4'd8 : in_valid_bytes;
  assign nb    = in_last_word ? vb_n : 4'd8;
  assign dm    = in_data_word & byte_mask(nb);
  assign first = (wc_r == '0);
  assign hl_c  = first ? ((in_header_len < 6'd20) ? 6'd20 : in_header_len) : hl_r;
  assign tl_c  = first ? dm[47:32] : tl_r;

  always_comb begin
    logic [IW-1:0] i;
    logic [7:0]    b;
    logic [15:0]   w;
    logic [15:0]   i16;
    logic [6:0]    i7;
    s1_nxt  = first ? 32'd0 : s1_r;
    s2_nxt  = first ? 32'd0 : s2_r;
    s3_nxt  = first ? 32'd0 : s3_r;
    typ_nxt = first ? 8'd0 : typ_r;
    for (int j = 0; j < 8; j++) begin
      i   = {wc_r, 3'(j)};
      b   = dm[63-8*j -: 8];
      i16 = 16'(i);
      i7  = 7'(i);
      w   = (i[0] == hl_c[0]) ? {b, 8'h00} : {8'h00, b};
      if (i16 >= 16'(hl_c) && i16 < tl_c) begin
        s1_nxt = s1_nxt + 32'(w);
        if (!(i16 < 16'(hl_c) + 16'd4)) s2_nxt = s2_nxt + 32'(w);
      end
      if (i16 < 16'(hl_c) && i7 != 7'd8 && i7 != 7'd10 && i7 != 7'd11) begin
        s3_nxt = s3_nxt + (i[0] ? 32'(b) : 32'({b, 8'h00}));
      end
      if (i16 == 16'(hl_c)) typ_nxt = b;
    end
  end

  always_comb begin
    priority if (ovf_r)                                     verdict_nxt = icmp_pkg::V_TOO_LONG;
    else if (tl_r < 16'(hl_r) || csum16(s1_r) != 16'd0)   verdict_nxt = icmp_pkg::V_CSUM_ERR;
    else if (typ_r == icmp_pkg::T_ECHO_REQ)                 verdict_nxt = icmp_pkg::V_REPLY;
    else if (typ_r == icmp_pkg::T_ECHO_REP)                 verdict_nxt = icmp_pkg::V_ECHO_REPLY;
    else if (typ_r == icmp_pkg::T_TIME_EXC)                 verdict_nxt = icmp_pkg::V_TIME_EXC;
    else                                                    verdict_nxt = icmp_pkg::V_OTHER;
  end

  icmp_ram #(
    .WIDTH(64),
    .DEPTH(icmp_pkg::MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && (wc_r < CW'(icmp_pkg::MAX_WORDS))),
    .waddr (wc_r[icmp_pkg::ADDR_W-1:0]),
    .wdata (dm),
    .raddr (ptr_r[icmp_pkg::ADDR_W-1:0]),
    .rdata (q)
  );

  assign last_w    = (ptr_r == wc_r - CW'(1));
  assign lat_bytes = last_w ? vb_r : 4'd8;

  always_comb begin
    logic [IW-1:0] i;
    logic [IW-1:0] h;
    for (int j = 0; j < 8; j++) begin
      i = {ptr_r, 3'(j)};
      h = IW'(hl_r);
      priority if (i == IW'(8))              xf[63-8*j -: 8] = ttl;
      else if (i == IW'(10))                 xf[63-8*j -: 8] = hc_r[15:8];
      else if (i == IW'(11))                 xf[63-8*j -: 8] = hc_r[7:0];
      else if (i >= IW'(12) && i < IW'(16))  xf[63-8*j -: 8] = a16_r[8*(3-i[1:0]) +: 8];
      else if (i >= IW'(16) && i < IW'(20))  xf[63-8*j -: 8] = a12_r[8*(3-i[1:0]) +: 8];
      else if (i == h || i == h + IW'(1))    xf[63-8*j -: 8] = 8'h00;
      else if (i == h + IW'(2))              xf[63-8*j -: 8] = ic_r[15:8];
      else if (i == h + IW'(3))              xf[63-8*j -: 8] = ic_r[7:0];
      else                                   xf[63-8*j -: 8] = q[63-8*j -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= '0;
      ovf_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      if (cmd.load) begin
        if (wc_r < CW'(icmp_pkg::MAX_WORDS)) wc_r <= wc_r + CW'(1);
        else                                 ovf_r <= 1'b1;
      end
      if (cmd.fold) ptr_r <= '0;
      if (cmd.lat)  ptr_r <= ptr_r + CW'(1);
      if (cmd.clear) begin
        wc_r  <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hl_r  <= hl_c;
      tl_r  <= tl_c;
      vb_r  <= vb_n;
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      typ_r <= typ_nxt;
      if (first) begin
        a12_r <= 32'd0;
        a16_r <= 32'd0;
      end
      if (wc_r == CW'(1)) a12_r <= dm[31:0];
      if (wc_r == CW'(2)) a16_r <= dm[63:32];
    end
    if (cmd.fold) begin
      verdict_r <= verdict_nxt;
      ic_r      <= csum16(s2_r);
      hc_r      <= csum16(s3_r + {16'd0, ttl, 8'h00});
    end
    if (cmd.status) begin
      out_word_r    <= 64'd0;
      out_bytes_r   <= 4'd0;
      out_last_r    <= 1'b1;
      out_verdict_r <= verdict_r;
      out_peer_r    <= a12_r;
    end
    if (cmd.lat) begin
      out_word_r    <= xf & byte_mask(lat_bytes);
      out_bytes_r   <= lat_bytes;
      out_last_r    <= last_w;
      out_verdict_r <= icmp_pkg::V_REPLY;
      out_peer_r    <= 32'd0;
    end
  end

  assign sts.reply     = (verdict_r == icmp_pkg::V_REPLY);
  assign sts.last      = out_last_r;
  assign out_word      = out_word_r;
  assign out_bytes     = out_bytes_r;
  assign out_last      = out_last_r;
  assign out_verdict   = out_verdict_r;
  assign out_peer_addr = out_peer_r;

endmodule

FILE: dv/icmp_echo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo responder checker
// Watches the request, result and configuration channels, predicts the reply
// or status items of each packet and compares every result field by field.
// ----------------------------------------------------------------------------
module icmp_echo_checker
  import icmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_word,
  input  logic [5:0]  in_header_len,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_word,
  input  logic [3:0]  out_bytes,
  input  logic        out_last,
  input  logic [2:0]  out_verdict,
  input  logic [31:0] out_peer_addr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_reply_ttl,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic [2:0]  verdict;
    logic [31:0] peer;
  } reply_item_t;

  reply_item_t expected_q[$];

  logic [7:0] pkt_bytes [0:MAX_WORDS*8-1];
  int         words_held;
  int         hdr_len_held;
  bit         overflow;
  logic [7:0] ttl;

  function automatic logic [7:0] get_byte(int i, int plen);
    if (i >= plen || i >= MAX_WORDS * 8) return 8'h00;
    return pkt_bytes[i];
  endfunction

  function automatic void put_byte(int i, int plen, logic [7:0] v);
    if (i < plen && i < MAX_WORDS * 8) pkt_bytes[i] = v;
  endfunction

  function automatic logic [15:0] ones_sum(int start, int cnt, int plen);
    int unsigned acc;
    acc = 0;
    for (int k = 0; k < cnt && start + k < plen; k++) begin
      acc += (k & 1) ? get_byte(start + k, plen) : (get_byte(start + k, plen) << 8);
    end
    acc = (acc & 16'hffff) + (acc >> 16);
    acc = (acc & 16'hffff) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  task automatic finish_packet(int vb);
    int          plen, hl, tl;
    logic [31:0] peer;
    logic [2:0]  vd;
    logic [7:0]  t, a;
    logic [15:0] c;
    reply_item_t r;
    plen = overflow ? MAX_WORDS * 8 : (words_held - 1) * 8 + vb;
    hl   = hdr_len_held < 20 ? 20 : hdr_len_held;
    tl   = {get_byte(2, plen), get_byte(3, plen)};
    peer = {get_byte(12, plen), get_byte(13, plen), get_byte(14, plen), get_byte(15, plen)};
    if (overflow) vd = V_TOO_LONG;
    else if (tl < hl || ones_sum(hl, tl - hl, plen) != 16'h0) vd = V_CSUM_ERR;
    else begin
      t = get_byte(hl, plen);
      if (t == T_ECHO_REQ) vd = V_REPLY;
      else if (t == T_ECHO_REP) vd = V_ECHO_REPLY;
      else if (t == T_TIME_EXC) vd = V_TIME_EXC;
      else vd = V_OTHER;
    end
    if (vd != V_REPLY) begin
      r = '{64'h0, 4'd0, 1'b1, vd, peer};
      expected_q.push_back(r);
    end else begin
      for (int k = 0; k < 4; k++) put_byte(hl + k, plen, 8'h00);
      c = ones_sum(hl, tl - hl, plen);
      put_byte(hl + 2, plen, c[15:8]);
      put_byte(hl + 3, plen, c[7:0]);
      for (int k = 0; k < 4; k++) begin
        a = get_byte(12 + k, plen);
        put_byte(12 + k, plen, get_byte(16 + k, plen));
        put_byte(16 + k, plen, a);
      end
      put_byte(8, plen, ttl);
      put_byte(10, plen, 8'h00);
      put_byte(11, plen, 8'h00);
      c = ones_sum(0, hl, plen);
      put_byte(10, plen, c[15:8]);
      put_byte(11, plen, c[7:0]);
      for (int k = 0; k < words_held; k++) begin
        r.nbytes  = (k + 1 == words_held) ? 4'(vb) : 4'd8;
        r.last    = (k + 1 == words_held);
        r.verdict = V_REPLY;
        r.peer    = 32'h0;
        for (int b = 0; b < 8; b++) begin
          r.word[63 - 8*b -: 8] = (b < r.nbytes) ? pkt_bytes[k*8 + b] : 8'h00;
        end
        expected_q.push_back(r);
      end
    end
    words_held = 0;
    overflow   = 0;
  endtask

  always @(posedge clk) begin
    int          vb;
    reply_item_t e;
    if (!rst_n) begin
      words_held   = 0;
      hdr_len_held = 0;
      overflow     = 0;
      ttl          = 8'd255;
      fail_count   <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) ttl = cfg_reply_ttl;
      if (in_valid && in_ready) begin
        vb = in_valid_bytes;
        if (vb == 0 || vb > 8) vb = 8;
        if (words_held == 0) hdr_len_held = in_header_len;
        if (words_held < MAX_WORDS) begin
          for (int b = 0; b < 8; b++) begin
            pkt_bytes[words_held*8 + b] =
              (in_last_word && b >= vb) ? 8'h00 : in_data_word[63 - 8*b -: 8];
          end
          words_held = words_held + 1;
        end else begin
          overflow = 1;
        end
        if (in_last_word) finish_packet(vb);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word=%h bytes=%0d last=%0b verdict=%0d peer=%h",
                   $time, out_word, out_bytes, out_last, out_verdict, out_peer_addr);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_word !== e.word || out_bytes !== e.nbytes || out_last !== e.last ||
              out_verdict !== e.verdict || out_peer_addr !== e.peer) begin
            $display("%0t: mismatch expected word=%h bytes=%0d last=%0b verdict=%0d peer=%h",
                     $time, e.word, e.nbytes, e.last, e.verdict, e.peer);
            $display("%0t:          actual   word=%h bytes=%0d last=%0b verdict=%0d peer=%h",
                     $time, out_word, out_bytes, out_last, out_verdict, out_peer_addr);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo responder testbench
// Sends directed and random IPv4 packets with random idling on both channels,
// rewrites the reply TTL between phases and lets the checker judge results.
// ----------------------------------------------------------------------------
module testbench;
  import icmp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [63:0] in_data_word;
  logic [3:0]  in_valid_bytes;
  logic        in_last_word;
  logic [5:0]  in_header_len;
  logic        out_valid, out_ready;
  logic [63:0] out_word;
  logic [3:0]  out_bytes;
  logic        out_last;
  logic [2:0]  out_verdict;
  logic [31:0] out_peer_addr;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_reply_ttl;

  int fail_count, pending, results_seen;
  int cycles = 0;
  int words_sent = 0;
  int packets_sent = 0;
  bit quiet = 0;
  bit hold_req = 0;

  icmp_echo_responder_top u_dut (.*);

  icmp_echo_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] fold16(logic [7:0] pkt[], int start, int cnt);
    int unsigned acc;
    acc = 0;
    for (int k = 0; k < cnt; k++)
      acc += (k & 1) ? pkt[start + k] : (pkt[start + k] << 8);
    acc = (acc & 16'hffff) + (acc >> 16);
    acc = (acc & 16'hffff) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  task automatic send_word(logic [63:0] d, logic [3:0] vb, logic lst, logic [5:0] hl);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_word   <= d;
    in_valid_bytes <= vb;
    in_last_word   <= lst;
    in_header_len  <= hl;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_packet(int hl_field, int icmp_len, logic [7:0] itype,
                             bit corrupt, int tl_delta, logic [3:0] tail_vb);
    logic [7:0]  pkt[];
    logic [15:0] c;
    logic [63:0] d;
    int          hle, total, nw, vb;
    hle   = hl_field < 20 ? 20 : hl_field;
    total = hle + icmp_len;
    pkt   = new[total + 8];
    foreach (pkt[i]) pkt[i] = $urandom_range(0, 255);
    {pkt[2], pkt[3]} = 16'(total + tl_delta);
    if (icmp_len > 0) pkt[hle] = itype;
    if (icmp_len > 3) begin
      pkt[hle+2] = 8'h00;
      pkt[hle+3] = 8'h00;
      c = fold16(pkt, hle, icmp_len);
      pkt[hle+2] = c[15:8];
      pkt[hle+3] = c[7:0];
    end
    if (corrupt && icmp_len > 1) pkt[hle+1] ^= 8'h01;
    nw = (total + 7) / 8;
    vb = total - 8 * (nw - 1);
    for (int w = 0; w < nw; w++) begin
      for (int b = 0; b < 8; b++) d[63 - 8*b -: 8] = pkt[w*8 + b];
      send_word(d, (w == nw - 1) ? ((tail_vb != 0) ? tail_vb : 4'(vb)) : 4'($urandom),
                w == nw - 1, (w == 0) ? 6'(hl_field) : 6'($urandom));
    end
    packets_sent++;
  endtask

  task automatic drain_and_write_ttl(logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_reply_ttl <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int itype_pick;
    logic [7:0] itype;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_word   <= '0;
    in_valid_bytes <= '0;
    in_last_word   <= 1'b0;
    in_header_len  <= '0;
    cfg_valid      <= 1'b0;
    cfg_reply_ttl  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    drain_and_write_ttl(8'd0);
    send_packet(20, 8, T_ECHO_REQ, 0, 0, 0);
    send_packet(60, 13, T_ECHO_REQ, 0, 0, 0);
    send_packet(5, 9, T_ECHO_REP, 0, 0, 0);
    send_packet(24, 8, T_TIME_EXC, 0, 0, 0);
    send_packet(20, 12, 8'd3, 0, 0, 0);
    send_packet(20, 12, T_ECHO_REQ, 1, 0, 0);
    send_packet(32, 8, T_ECHO_REQ, 0, -40, 0);
    send_packet(63, 17, T_ECHO_REQ, 0, 6, 0);
    send_packet(20, 12, T_ECHO_REQ, 0, 0, 4'd0);
    send_packet(20, 12, T_ECHO_REQ, 0, 0, 4'd15);
    drain_and_write_ttl(8'($urandom_range(0, 255)));
    send_packet(20, $urandom_range(493, 500), T_ECHO_REQ, 0, 0, 0);

    while (words_sent < 130) begin
      if (packets_sent % 7 == 0) drain_and_write_ttl($urandom_range(0, 255));
      if (packets_sent == 11) hold_req = 1;
      if (words_sent > 120) quiet = 1;
      itype_pick = $urandom_range(0, 9);
      itype = (itype_pick < 6) ? T_ECHO_REQ : (itype_pick == 6) ? T_ECHO_REP :
              (itype_pick == 7) ? T_TIME_EXC : 8'($urandom);
      send_packet(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : 20,
                  $urandom_range(8, 24), itype, $urandom_range(0, 9) == 0,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) - 6 : 0,
                  ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d packets in %0d words with TTL rewrites and stalls;", packets_sent,
             words_sent);
    $display("checked %0d results incl. replies, status items and an oversized packet.",
             results_seen);
    if (fail_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
